>>> sv/ecph_pkg.sv
`timescale 1ns / 1ps
package ecph_pkg;

   // Field widths fixed by the byte protocol and the timer registers.
   localparam int BYTE_W  = 8;
   localparam int RATE_W  = 24;
   localparam int DATA_W  = 16;
   localparam int LED_W   = 4;
   localparam int POS_W   = 3;

   // Protocol codes.
   localparam logic [BYTE_W-1:0] START_BYTE    = 8'hFF;
   localparam logic [BYTE_W-1:0] FORCED_BYTE   = 8'hFF;
   localparam logic [BYTE_W-1:0] ESC_NONE      = 8'h00;
   localparam logic [BYTE_W-1:0] ESC_LOW       = 8'h01;
   localparam logic [BYTE_W-1:0] ESC_HIGH      = 8'h02;
   localparam logic [BYTE_W-1:0] ESC_BOTH      = 8'h03;
   localparam logic [BYTE_W-1:0] CMD_LAST_LED  = 8'h03;
   localparam logic [BYTE_W-1:0] CMD_SET_TIMER = 8'h04;

   // Reset values of the registers.
   localparam logic [RATE_W-1:0] RATE_RESET    = 24'd1000000;
   localparam logic [DATA_W-1:0] PERIOD_RESET  = 16'd999;
   localparam logic [DATA_W-1:0] COMPARE_RESET = 16'd500;

   // Places of the five echoed words of one packet.
   localparam logic [POS_W-1:0] POS_START = 3'd0;
   localparam logic [POS_W-1:0] POS_CMD   = 3'd1;
   localparam logic [POS_W-1:0] POS_HIGH  = 3'd2;
   localparam logic [POS_W-1:0] POS_LOW   = 3'd3;
   localparam logic [POS_W-1:0] POS_ESC   = 3'd4;

   // A gathered packet with its escape already applied.
   typedef struct packed {
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] high_data;
      logic [BYTE_W-1:0] low_data;
      logic [BYTE_W-1:0] escape;
   } pkt_type;

   // One result word as the back end presents it.
   typedef struct packed {
      logic [BYTE_W-1:0] echo_byte;
      logic              last_of_packet;
      logic [LED_W-1:0]  led_bits;
      logic [DATA_W-1:0] period_value;
      logic [DATA_W-1:0] compare_value;
      logic              divide_by_zero;
   } rsp_word_type;

   typedef enum logic [2:0] {
      FRONT_HUNT,
      FRONT_CMD,
      FRONT_HIGH,
      FRONT_LOW,
      FRONT_ESC
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_EMIT
   } back_state_type;

endpackage

>>> sv/ecph_div.sv
`timescale 1ns / 1ps
module ecph_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ecph_pkg::RATE_W-1:0]   dividend,
   input  logic [ecph_pkg::DATA_W-1:0]   divisor,
   output logic                          done,
   output logic [ecph_pkg::RATE_W-1:0]   quotient
);
   import ecph_pkg::*;

   localparam int CNT_W = $clog2(RATE_W);

   logic [RATE_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;
   logic              fits;

   // One restoring step: shift in the next dividend bit and try the subtract.
   always_comb begin
      shifted = {rem_ff, quo_ff[RATE_W-1]};
      diff    = shifted - {1'b0, div_ff};
      fits    = (shifted >= {1'b0, div_ff});
   end

   // Sequencing of the quotient bits, most significant first.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(RATE_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[RATE_W-2:0], fits};
         rem_in = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/ecph_front.sv
`timescale 1ns / 1ps
module ecph_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [ecph_pkg::BYTE_W-1:0] rx_byte,
   output logic                        pkt_push,
   output ecph_pkg::pkt_type           pkt_data
);
   import ecph_pkg::*;

   front_state_type   state_ff, state_in;
   logic [BYTE_W-1:0] cmd_ff, hi_ff, lo_ff;

   // Next state: hunt for the start byte, then gather four bytes.
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         unique case (state_ff)
            FRONT_HUNT: state_in = (rx_byte == START_BYTE) ? FRONT_CMD : FRONT_HUNT;
            FRONT_CMD:  state_in = FRONT_HIGH;
            FRONT_HIGH: state_in = FRONT_LOW;
            FRONT_LOW:  state_in = FRONT_ESC;
            FRONT_ESC:  state_in = FRONT_HUNT;
            default:    state_in = FRONT_HUNT;
         endcase
      end
   end

   // Outputs: the escape byte completes the packet and applies the escape.
   always_comb begin
      pkt_push           = accept && (state_ff == FRONT_ESC);
      pkt_data.command   = cmd_ff;
      pkt_data.high_data = hi_ff;
      pkt_data.low_data  = lo_ff;
      pkt_data.escape    = rx_byte;
      unique case (rx_byte)
         ESC_LOW: begin
            pkt_data.low_data = FORCED_BYTE;
            pkt_data.escape   = ESC_NONE;
         end
         ESC_HIGH: begin
            pkt_data.high_data = FORCED_BYTE;
            pkt_data.escape    = ESC_NONE;
         end
         ESC_BOTH: begin
            pkt_data.high_data = FORCED_BYTE;
            pkt_data.low_data  = FORCED_BYTE;
            pkt_data.escape    = ESC_NONE;
         end
         default: begin
         end
      endcase
   end

   // State and the held packet bytes.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_HUNT;
      end else begin
         state_ff <= state_in;
      end
      if (accept && state_ff == FRONT_CMD) begin
         cmd_ff <= rx_byte;
      end
      if (accept && state_ff == FRONT_HIGH) begin
         hi_ff <= rx_byte;
      end
      if (accept && state_ff == FRONT_LOW) begin
         lo_ff <= rx_byte;
      end
   end

endmodule

>>> sv/ecph_queue.sv
`timescale 1ns / 1ps
module ecph_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ecph_pkg::pkt_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output ecph_pkg::pkt_type pop_data
);
   import ecph_pkg::*;

   localparam int AW = $clog2(DEPTH);

   pkt_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in;
   logic [AW-1:0]   rd_ff, rd_in;
   logic [AW:0]     count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> sv/ecph_back.sv
`timescale 1ns / 1ps
module ecph_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ecph_pkg::RATE_W-1:0] clock_rate,
   input  logic                        pkt_empty,
   input  ecph_pkg::pkt_type           pkt_data,
   output logic                        pkt_pop,
   output logic                        word_valid,
   input  logic                        word_pop,
   output ecph_pkg::rsp_word_type      word
);
   import ecph_pkg::*;

   back_state_type    state_ff, state_in;
   pkt_type           pkt_ff, pkt_in;
   logic [LED_W-1:0]  led_ff, led_in;
   logic [DATA_W-1:0] period_ff, period_in;
   logic [DATA_W-1:0] compare_ff, compare_in;
   logic              dz_ff, dz_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              div_start;
   logic              div_done;
   logic [RATE_W-1:0] quotient;
   logic [DATA_W-1:0] data;
   logic              take;

   ecph_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clock_rate),
      .divisor  (data),
      .done     (div_done),
      .quotient (quotient)
   );

   assign data = {pkt_data.high_data, pkt_data.low_data};
   assign take = (state_ff == BACK_IDLE) && !pkt_empty;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!pkt_empty) begin
               if (pkt_data.command == CMD_SET_TIMER && data != '0) begin
                  state_in = BACK_DIVIDE;
               end else begin
                  state_in = BACK_EMIT;
               end
            end
         end
         BACK_DIVIDE: begin
            if (div_done) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (word_pop && pos_ff == POS_ESC) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      pkt_pop    = take;
      div_start  = take && (pkt_data.command == CMD_SET_TIMER) && (data != '0);
      word_valid = (state_ff == BACK_EMIT);
   end

   // Command execution and register updates.
   always_comb begin
      pkt_in     = pkt_ff;
      led_in     = led_ff;
      period_in  = period_ff;
      compare_in = compare_ff;
      dz_in      = dz_ff;
      pos_in     = pos_ff;
      if (take) begin
         pkt_in = pkt_data;
         pos_in = POS_START;
         dz_in  = (pkt_data.command == CMD_SET_TIMER) && (data == '0);
         if (pkt_data.command <= CMD_LAST_LED) begin
            led_in = led_ff ^ (LED_W'(1) << pkt_data.command[1:0]);
         end
      end
      if (state_ff == BACK_DIVIDE && div_done) begin
         period_in  = quotient[DATA_W-1:0];
         compare_in = {1'b0, quotient[DATA_W-1:1]};
      end
      if (state_ff == BACK_EMIT && word_pop) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   // Result word selection.
   always_comb begin
      word.last_of_packet = (pos_ff == POS_ESC);
      word.led_bits       = led_ff;
      word.period_value   = period_ff;
      word.compare_value  = compare_ff;
      word.divide_by_zero = dz_ff;
      unique case (pos_ff)
         POS_START: word.echo_byte = START_BYTE;
         POS_CMD:   word.echo_byte = pkt_ff.command;
         POS_HIGH:  word.echo_byte = pkt_ff.high_data;
         POS_LOW:   word.echo_byte = pkt_ff.low_data;
         default:   word.echo_byte = pkt_ff.escape;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BACK_IDLE;
         led_ff     <= '0;
         period_ff  <= PERIOD_RESET;
         compare_ff <= COMPARE_RESET;
         dz_ff      <= 1'b0;
         pos_ff     <= POS_START;
      end else begin
         state_ff   <= state_in;
         led_ff     <= led_in;
         period_ff  <= period_in;
         compare_ff <= compare_in;
         dz_ff      <= dz_in;
         pos_ff     <= pos_in;
      end
      pkt_ff <= pkt_in;
   end

endmodule

>>> sv/escaped_command_packet_handler_top.sv
`timescale 1ns / 1ps
// Escaped command packet handler.
// Input: received bytes are pushed on req_rx_byte with req_push while req_full
// is low. Bytes are dropped until 0xFF; then command, high data, low data and
// escape bytes form a packet, which goes into a small packet queue.
// Output: each packet comes back as five words (0xFF, command, high, low,
// escape with the escape applied), each with the LED, period and compare
// values after the packet. A word waits on the rsp_ ports while rsp_empty is
// low and leaves on rsp_pop.
// Configuration: csr_timer_clock_rate is written when csr_valid is high; the
// port is always ready. Write it only while no packet is in flight.
// Timing: bytes enter one per cycle while the queue has room. A packet is
// written into the queue when its escape byte enters and is taken from there by
// the back end; a timer command with nonzero data then passes through the
// one-bit-per-cycle divider before its words are shown. The back end hands out
// the five words one per pop and takes the next packet after the last has left.
// Reset clears the LEDs, loads period 999 and compare 500 and hunts for 0xFF.
// A stalled receiver holds the back end; the front keeps taking bytes until
// the queue is full, then raises req_full.
module escaped_command_packet_handler_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [ecph_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [ecph_pkg::BYTE_W-1:0] rsp_echo_byte,
   output logic                        rsp_last_of_packet,
   output logic [ecph_pkg::LED_W-1:0]  rsp_led_bits,
   output logic [ecph_pkg::DATA_W-1:0] rsp_period_value,
   output logic [ecph_pkg::DATA_W-1:0] rsp_compare_value,
   output logic                        rsp_divide_by_zero,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ecph_pkg::RATE_W-1:0] csr_timer_clock_rate
);
   import ecph_pkg::*;

   logic [RATE_W-1:0] rate_ff;
   logic              accept;
   logic              q_push, q_pop, q_full, q_empty;
   pkt_type           q_in, q_out;
   logic              word_valid;
   rsp_word_type      word;

   // Clock rate register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else if (csr_valid && csr_ready) begin
         rate_ff <= csr_timer_clock_rate;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   ecph_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .rx_byte  (req_rx_byte),
      .pkt_push (q_push),
      .pkt_data (q_in)
   );

   ecph_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .pop_data  (q_out)
   );

   ecph_back u_back (
      .clock      (clock),
      .reset      (reset),
      .clock_rate (rate_ff),
      .pkt_empty  (q_empty),
      .pkt_data   (q_out),
      .pkt_pop    (q_pop),
      .word_valid (word_valid),
      .word_pop   (rsp_pop),
      .word       (word)
   );

   // Result ports.
   assign rsp_empty          = !word_valid;
   assign rsp_echo_byte      = word.echo_byte;
   assign rsp_last_of_packet = word.last_of_packet;
   assign rsp_led_bits       = word.led_bits;
   assign rsp_period_value   = word.period_value;
   assign rsp_compare_value  = word.compare_value;
   assign rsp_divide_by_zero = word.divide_by_zero;

   // The back end goes idle after the last word of a packet leaves.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_last_of_packet) |=> rsp_empty)
      else $error("result still shown after the last word of a packet");

   // The compare value never exceeds the period.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_compare_value <= rsp_period_value))
      else $error("compare value above period");

   // A finished packet is never offered to a full queue.
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("packet pushed into a full queue");

   // The back end only takes a packet that the queue holds.
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("packet taken from an empty queue");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import ecph_pkg::*;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_push;
   logic                req_full;
   logic [BYTE_W-1:0]   req_rx_byte;
   logic                rsp_empty;
   logic                rsp_pop;
   logic [BYTE_W-1:0]   rsp_echo_byte;
   logic                rsp_last_of_packet;
   logic [LED_W-1:0]    rsp_led_bits;
   logic [DATA_W-1:0]   rsp_period_value;
   logic [DATA_W-1:0]   rsp_compare_value;
   logic                rsp_divide_by_zero;
   logic                csr_valid;
   logic                csr_ready;
   logic [RATE_W-1:0]   csr_timer_clock_rate;

   // Bytes waiting to be pushed and echo words still to come back.
   logic [BYTE_W-1:0]   pending_bytes[$];
   rsp_word_type        echo_words_due[$];

   // Shadow copy of the packet handler state.
   logic [POS_W-1:0]    shadow_pos;
   logic [BYTE_W-1:0]   shadow_cmd;
   logic [BYTE_W-1:0]   shadow_high;
   logic [BYTE_W-1:0]   shadow_low;
   logic [LED_W-1:0]    shadow_leds;
   logic [DATA_W-1:0]   shadow_period;
   logic [DATA_W-1:0]   shadow_compare;
   logic [RATE_W-1:0]   shadow_rate;

   bit                  sender_idles = 1'b1;
   bit                  receiver_idles = 1'b1;
   int                  hold_request = 0;
   int                  hold_left = 0;
   int                  mismatches = 0;

   escaped_command_packet_handler_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_rx_byte          (req_rx_byte),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_echo_byte        (rsp_echo_byte),
      .rsp_last_of_packet   (rsp_last_of_packet),
      .rsp_led_bits         (rsp_led_bits),
      .rsp_period_value     (rsp_period_value),
      .rsp_compare_value    (rsp_compare_value),
      .rsp_divide_by_zero   (rsp_divide_by_zero),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_timer_clock_rate (csr_timer_clock_rate)
   );

   always #1 clock = ~clock;

   // Advance the shadow state by one accepted byte and queue the echo words
   // of a packet once its escape byte has arrived.
   function automatic void track_rx_byte(input logic [BYTE_W-1:0] rx);
      logic [BYTE_W-1:0] esc;
      logic [DATA_W-1:0] data;
      logic [RATE_W-1:0] quotient;
      logic              zero_data;
      logic [BYTE_W-1:0] echo_list[5];
      rsp_word_type      word;
      case (shadow_pos)
         POS_CMD: begin
            shadow_cmd = rx;
            shadow_pos = POS_HIGH;
         end
         POS_HIGH: begin
            shadow_high = rx;
            shadow_pos = POS_LOW;
         end
         POS_LOW: begin
            shadow_low = rx;
            shadow_pos = POS_ESC;
         end
         POS_ESC: begin
            shadow_pos = POS_START;
            esc = rx;
            zero_data = 1'b0;
            if (esc == ESC_LOW) begin
               shadow_low = FORCED_BYTE;
               esc = ESC_NONE;
            end else if (esc == ESC_HIGH) begin
               shadow_high = FORCED_BYTE;
               esc = ESC_NONE;
            end else if (esc == ESC_BOTH) begin
               shadow_low = FORCED_BYTE;
               shadow_high = FORCED_BYTE;
               esc = ESC_NONE;
            end
            data = {shadow_high, shadow_low};
            // LED toggles, timer load, or nothing for unknown commands.
            if (shadow_cmd <= CMD_LAST_LED) begin
               shadow_leds = shadow_leds ^ (4'b0001 << shadow_cmd[1:0]);
            end else if (shadow_cmd == CMD_SET_TIMER) begin
               if (data == '0) begin
                  zero_data = 1'b1;
               end else begin
                  quotient = shadow_rate / data;
                  shadow_period = quotient[15:0];
                  shadow_compare = {1'b0, quotient[15:1]};
               end
            end
            echo_list[0] = START_BYTE;
            echo_list[1] = shadow_cmd;
            echo_list[2] = shadow_high;
            echo_list[3] = shadow_low;
            echo_list[4] = esc;
            for (int k = 0; k < 5; k++) begin
               word.echo_byte      = echo_list[k];
               word.last_of_packet = (k == 4);
               word.led_bits       = shadow_leds;
               word.period_value   = shadow_period;
               word.compare_value  = shadow_compare;
               word.divide_by_zero = zero_data;
               echo_words_due.push_back(word);
            end
         end
         default: begin
            shadow_pos = (rx == START_BYTE) ? POS_CMD : POS_START;
         end
      endcase
   endfunction

   // Compare one popped word against the oldest word still due.
   function automatic void check_echo_word();
      rsp_word_type got;
      rsp_word_type want;
      got.echo_byte      = rsp_echo_byte;
      got.last_of_packet = rsp_last_of_packet;
      got.led_bits       = rsp_led_bits;
      got.period_value   = rsp_period_value;
      got.compare_value  = rsp_compare_value;
      got.divide_by_zero = rsp_divide_by_zero;
      if (echo_words_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected word: echo=%h last=%b", got.echo_byte, got.last_of_packet);
         return;
      end
      want = echo_words_due.pop_front();
      if (got.echo_byte !== want.echo_byte || got.last_of_packet !== want.last_of_packet ||
          got.led_bits !== want.led_bits || got.period_value !== want.period_value ||
          got.compare_value !== want.compare_value ||
          got.divide_by_zero !== want.divide_by_zero) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch expected: echo=%h last=%b led=%h period=%0d compare=%0d dz=%b",
                     want.echo_byte, want.last_of_packet, want.led_bits,
                     want.period_value, want.compare_value, want.divide_by_zero);
            $display("         actual:   echo=%h last=%b led=%h period=%0d compare=%0d dz=%b",
                     got.echo_byte, got.last_of_packet, got.led_bits,
                     got.period_value, got.compare_value, got.divide_by_zero);
         end
      end
   endfunction

   // Byte driver: note each accepted byte, then offer the next one.
   always @(posedge clock) begin
      if (!reset && req_push && !req_full)
         track_rx_byte(pending_bytes.pop_front());
      if (!reset && pending_bytes.size() > 0 &&
          !(sender_idles && $urandom_range(99) < 7)) begin
         req_push    <= 1'b1;
         req_rx_byte <= pending_bytes[0];
      end else begin
         req_push    <= 1'b0;
      end
   end

   // Word receiver: check each popped word, then decide whether to pop next.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         check_echo_word();
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !reset && !(receiver_idles && $urandom_range(99) < 7);
      end
   end

   // Hand one byte to the driver, keeping only a short backlog.
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      while (pending_bytes.size() >= 2)
         @(posedge clock);
      pending_bytes.push_back(value);
   endtask

   task automatic send_packet(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] high,
                              input logic [BYTE_W-1:0] low, input logic [BYTE_W-1:0] esc);
      send_byte(START_BYTE);
      send_byte(cmd);
      send_byte(high);
      send_byte(low);
      send_byte(esc);
   endtask

   // Wait until every byte is taken and every word is back, then let the
   // divider and the packet queue run dry.
   task automatic settle_block();
      while (pending_bytes.size() > 0 || echo_words_due.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_timer_rate(input logic [RATE_W-1:0] value);
      settle_block();
      csr_valid            <= 1'b1;
      csr_timer_clock_rate <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid            <= 1'b0;
      shadow_rate = value;
   endtask

   function automatic logic [BYTE_W-1:0] random_command();
      int pick;
      pick = $urandom_range(9);
      if (pick <= 3)
         return BYTE_W'(pick);
      else if (pick <= 5)
         return CMD_SET_TIMER;
      else if (pick == 6)
         return BYTE_W'($urandom_range(5, 255));
      return BYTE_W'($urandom_range(255));
   endfunction

   function automatic logic [DATA_W-1:0] random_data();
      case ($urandom_range(4))
         0: return '0;
         1: return DATA_W'($urandom_range(1, 15));
         2: return 16'hFFFF;
         default: return DATA_W'($urandom_range(16'hFFFF));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] random_escape();
      int pick;
      pick = $urandom_range(7);
      if (pick <= 3)
         return BYTE_W'(pick);
      else if (pick == 4)
         return 8'hFF;
      return BYTE_W'($urandom_range(4, 255));
   endfunction

   function automatic logic [RATE_W-1:0] random_rate();
      case ($urandom_range(3))
         0: return 24'hFFFFFF;
         1: return RATE_W'($urandom_range(1, 255));
         default: return RATE_W'($urandom_range(1, 24'hFFFFFF));
      endcase
   endfunction

   // Noise, each escape, zero data on a timer command and an unknown command.
   task automatic test_directed_packets();
      send_byte(8'h00);
      send_byte(8'h7E);
      send_packet(8'h00, 8'h12, 8'h34, ESC_LOW);
      send_packet(CMD_SET_TIMER, 8'h00, 8'h00, ESC_NONE);
      send_packet(CMD_SET_TIMER, 8'h00, 8'h01, ESC_HIGH);
      send_packet(8'hFF, 8'h80, 8'h00, ESC_BOTH);
   endtask

   // Largest and smallest clock rates, with quotients that wrap or vanish.
   task automatic test_rate_extremes();
      write_timer_rate(24'hFFFFFF);
      send_packet(CMD_SET_TIMER, 8'h00, 8'h01, ESC_NONE);
      send_packet(CMD_SET_TIMER, 8'h00, 8'h00, ESC_BOTH);
      write_timer_rate(24'd1);
      send_packet(CMD_SET_TIMER, 8'h00, 8'h02, ESC_NONE);
      send_packet(CMD_SET_TIMER, 8'h00, 8'h01, 8'h04);
      write_timer_rate(RATE_RESET);
   endtask

   // The receiver holds off while packets keep coming, so the input stalls.
   task automatic test_full_queue();
      hold_request = 300;
      for (int n = 0; n < 6; n++)
         send_packet(random_command(), BYTE_W'($urandom_range(255)),
                     BYTE_W'($urandom_range(255)), random_escape());
   endtask

   // Mostly well-formed packets with random content, some noise and some
   // packets cut short, with a stretch where neither side idles.
   task automatic test_random_traffic();
      int packet_bytes;
      int pick;
      logic [DATA_W-1:0] data;
      packet_bytes = 0;
      for (int n = 0; packet_bytes < 95; n++) begin
         if (n > 0 && n % 12 == 0)
            write_timer_rate(random_rate());
         sender_idles   = !(n >= 6 && n < 18);
         receiver_idles = !(n >= 6 && n < 18);
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_byte(BYTE_W'($urandom_range(255)));
         end else if (pick < 15) begin
            send_byte(START_BYTE);
            repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(255)));
         end else begin
            data = random_data();
            send_packet(random_command(), data[15:8], data[7:0], random_escape());
            packet_bytes += 5;
         end
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // Reset once, run the tests in turn, then report.
   initial begin
      reset                <= 1'b1;
      req_push             <= 1'b0;
      req_rx_byte          <= '0;
      rsp_pop              <= 1'b0;
      csr_valid            <= 1'b0;
      csr_timer_clock_rate <= RATE_RESET;
      shadow_pos     = POS_START;
      shadow_cmd     = '0;
      shadow_high    = '0;
      shadow_low     = '0;
      shadow_leds    = '0;
      shadow_period  = PERIOD_RESET;
      shadow_compare = COMPARE_RESET;
      shadow_rate    = RATE_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_packets();
      test_rate_extremes();
      test_full_queue();
      test_random_traffic();
      settle_block();
      if (mismatches == 0 && echo_words_due.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #500000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
